@@ design/fct_pkg.sv @@
// Shared types and constants for the frustum cull test block.
package fct_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } op_t;

    // What a multiplier issue feeds
    typedef enum logic [1:0] {
        MM_VP   = 2'd0,
        MM_SQ   = 2'd1,
        MM_DIST = 2'd2
    } mul_mode_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_VP,
        ST_VP_DRAIN,
        ST_EXT,
        ST_SQ,
        ST_SQ_DRAIN,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_COPY,
        ST_TEST,
        ST_TEST_DRAIN,
        ST_REPORT
    } state_t;

    // Last plane and last box corner
    localparam logic [2:0] PLANE_LAST  = 3'd5;
    localparam logic [2:0] CORNER_LAST = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic      cap;
        logic      elem_write;
        logic      mul_issue;
        mul_mode_t mode;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] term;
        logic [2:0] plane;
        logic [2:0] corner;
        logic      ext_issue;
        logic      sqrt_start;
        logic      div_start;
        logic      copy_write;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic unit_busy;
        logic len_ok;
    } status_t;

endpackage

@@ design/fct_ctrl.sv @@
// Controller state machine for the frustum cull test block.
module fct_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      operation,
    input  fct_pkg::status_t status,
    output fct_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done
);
    import fct_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] plane_reg, plane_next;
    logic [2:0] corner_reg, corner_next;
    logic       box_reg, box_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            plane_reg  <= '0;
            corner_reg <= '0;
            box_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            plane_reg  <= plane_next;
            corner_reg <= corner_next;
            box_reg    <= box_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        plane_next  = plane_reg;
        corner_next = corner_reg;
        box_next    = box_reg;
        cmd         = '0;
        cmd.mode    = MM_VP;
        cmd.row     = cnt_reg[5:4];
        cmd.col     = cnt_reg[3:2];
        cmd.term    = cnt_reg[1:0];
        cmd.plane   = plane_reg;
        cmd.corner  = corner_reg;
        busy        = (state_reg != ST_IDLE);
        done        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.cap     = 1'b1;
                    cnt_next    = '0;
                    plane_next  = '0;
                    corner_next = '0;
                    box_next    = (op_t'(operation) == OP_BOX);
                    unique case (op_t'(operation))
                        OP_LOAD:   state_next = ST_WRITE;
                        OP_BUILD:  state_next = ST_VP;
                        OP_SPHERE: state_next = ST_TEST;
                        OP_BOX:    state_next = ST_TEST;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.elem_write = 1'b1;
                state_next     = ST_IDLE;
            end
            // view times projection, one product per cycle
            ST_VP:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mode      = MM_VP;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = ST_VP_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_VP_DRAIN:
            begin
                if (cnt_reg[0])
                begin
                    cnt_next   = '0;
                    plane_next = '0;
                    state_next = ST_EXT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            // plane components from column sums and differences
            ST_EXT:
            begin
                cmd.ext_issue = 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_SQ:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mode      = MM_SQ;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_SQ_DRAIN:
            begin
                if (cnt_reg[0])
                    state_next = ST_SQRT;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (!status.unit_busy)
                begin
                    cnt_next   = '0;
                    state_next = status.len_ok ? ST_DIV : ST_COPY;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!status.unit_busy)
                begin
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        cnt_next   = '0;
                        plane_next = plane_reg + 3'd1;
                        state_next = (plane_reg == PLANE_LAST) ? ST_IDLE : ST_EXT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 6'd1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_COPY:
            begin
                cmd.copy_write = 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    plane_next = plane_reg + 3'd1;
                    state_next = (plane_reg == PLANE_LAST) ? ST_IDLE : ST_EXT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            // three products per corner, planes in order
            ST_TEST:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mode      = MM_DIST;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    cnt_next = '0;
                    if (!box_reg || corner_reg == CORNER_LAST)
                    begin
                        corner_next = '0;
                        plane_next  = plane_reg + 3'd1;
                        if (plane_reg == PLANE_LAST)
                            state_next = ST_TEST_DRAIN;
                    end
                    else
                        corner_next = corner_reg + 3'd1;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_TEST_DRAIN:
            begin
                if (cnt_reg[0])
                    state_next = ST_REPORT;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_REPORT:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

@@ design/fct_dp.sv @@
// Datapath: matrix stores, shared multiplier, square root, divider, planes.
module fct_dp #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fct_pkg::cmd_t       cmd,
    output fct_pkg::status_t    status,
    input  logic [1:0]          operation,
    input  logic [4:0]          element_index,
    input  logic signed [31:0]  element_value,
    input  logic signed [31:0]  point_a_x,
    input  logic signed [31:0]  point_a_y,
    input  logic signed [31:0]  point_a_z,
    input  logic signed [31:0]  point_b_x,
    input  logic signed [31:0]  point_b_y,
    input  logic signed [31:0]  point_b_z,
    input  logic [30:0]         sphere_radius,
    output logic                visible
);
    import fct_pkg::*;

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int P2W = 2 * W;
    localparam int NW  = W + F;
    localparam int CW  = $clog2(NW + 1);
    localparam logic signed [P2W-1:0] MAXV = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [P2W-1:0] MINV = {{(W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic [P2W-1:0] RND_MASK = {{(P2W - F){1'b0}}, {F{1'b1}}};
    localparam logic [W-1:0] EPS_RAW = W'(((1 << F) + 5000) / 10000);
    localparam logic [NW-1:0] Q_HALF = NW'(1) << (W - 1);
    localparam logic [5:0] PLANE_MINUS = 6'b100110;

    typedef struct packed {
        logic      vld;
        mul_mode_t mode;
        logic      first;
        logic      last;
        logic      cfirst;
        logic      clast;
        logic [3:0] idx;
    } tag_t;

    // saturate a wide signed value to the word
    function automatic logic signed [W-1:0] sat_w(input logic signed [P2W-1:0] v);
        logic signed [W-1:0] r;
        if (v > MAXV)
            r = MAXV[W-1:0];
        else if (v < MINV)
            r = MINV[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    // fixed point product, truncated toward zero
    function automatic logic signed [W-1:0] fx_of(input logic signed [P2W-1:0] p);
        logic signed [P2W-1:0] adj;
        adj = p + (p[P2W-1] ? signed'(RND_MASK) : '0);
        return sat_w(adj >>> F);
    endfunction

    // stores
    logic signed [W-1:0] view_mem_reg [16];
    logic signed [W-1:0] proj_mem_reg [16];
    logic signed [W-1:0] vp_mem_reg [16];
    logic signed [W-1:0] plane_mem_reg [24];
    logic [5:0]          plane_vld_reg;

    // latched item
    logic [4:0]          idx_reg;
    logic signed [W-1:0] val_reg, ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg, r_reg;
    logic                box_reg;

    // multiplier pipe
    logic signed [W-1:0]   mul_a_reg, mul_b_reg, d1_reg, d2_reg;
    logic signed [P2W-1:0] prod_reg;
    tag_t                  tag1_reg, tag2_reg, tag_next;
    logic signed [W-1:0]   coord;

    // accumulators
    logic signed [W+1:0]   vacc_reg, dacc_reg;
    logic [P2W+1:0]        sq_acc_reg;
    logic                  plane_in_reg, any_out_reg;
    logic signed [W-1:0]   fx;
    logic signed [W+1:0]   vsum, dsum;
    logic signed [W+2:0]   pdist;
    logic                  pin;

    // extraction
    logic signed [W-1:0] vp_a_reg, vp_b_reg;
    logic                ext_vld_reg, ext_minus_reg;
    logic [1:0]          ext_k_reg;
    logic signed [W-1:0] comp_reg [4];

    // square root
    logic                sqrt_busy_reg;
    logic [P2W-1:0]      s_reg;
    logic [W:0]          srem_reg;
    logic [W-1:0]        root_reg, len_reg;
    logic [CW-1:0]       scnt_reg;
    logic [W+2:0]        srem_sh, strial;

    // divider
    logic                div_busy_reg, div_neg_reg;
    logic [NW-1:0]       num_reg, q_reg, q_next;
    logic [W-1:0]        drem_reg, drem_next;
    logic [CW-1:0]       dcnt_reg;
    logic [4:0]          div_addr_reg;
    logic [W:0]          drem_sh;
    logic [W-1:0]        cmag;
    logic signed [W-1:0] div_res;

    // plane write port
    logic                pw_en;
    logic [4:0]          pw_addr;
    logic signed [W-1:0] pw_data;

    assign status.unit_busy = sqrt_busy_reg | div_busy_reg;
    assign status.len_ok    = (len_reg > EPS_RAW);
    assign visible          = ~any_out_reg;

    // capture item, write matrix elements
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            idx_reg <= element_index;
            val_reg <= sat_w(P2W'(element_value));
            ax_reg  <= sat_w(P2W'(point_a_x));
            ay_reg  <= sat_w(P2W'(point_a_y));
            az_reg  <= sat_w(P2W'(point_a_z));
            bx_reg  <= sat_w(P2W'(point_b_x));
            by_reg  <= sat_w(P2W'(point_b_y));
            bz_reg  <= sat_w(P2W'(point_b_z));
            r_reg   <= sat_w(signed'(P2W'(sphere_radius)));
            box_reg <= (op_t'(operation) == OP_BOX);
        end
        if (cmd.elem_write)
        begin
            if (idx_reg[4])
                proj_mem_reg[idx_reg[3:0]] <= val_reg;
            else
                view_mem_reg[idx_reg[3:0]] <= val_reg;
        end
    end

    // corner coordinate for the current term
    always_comb
    begin
        unique case (cmd.term)
            2'd0:    coord = cmd.corner[0] ? bx_reg : ax_reg;
            2'd1:    coord = cmd.corner[1] ? by_reg : ay_reg;
            default: coord = cmd.corner[2] ? bz_reg : az_reg;
        endcase
    end

    // issue tag
    always_comb
    begin
        tag_next        = '0;
        tag_next.vld    = cmd.mul_issue;
        tag_next.mode   = cmd.mode;
        tag_next.idx    = {cmd.row, cmd.col};
        tag_next.cfirst = (cmd.corner == 3'd0);
        tag_next.clast  = !box_reg || (cmd.corner == CORNER_LAST);
        unique case (cmd.mode)
            MM_VP:
            begin
                tag_next.first = (cmd.term == 2'd0);
                tag_next.last  = (cmd.term == 2'd3);
            end
            default:
            begin
                tag_next.first = (cmd.term == 2'd0);
                tag_next.last  = (cmd.term == 2'd2);
            end
        endcase
    end

    // operand read and multiply
    always_ff @(posedge clk)
    begin
        unique case (cmd.mode)
            MM_VP:
            begin
                mul_a_reg <= view_mem_reg[{cmd.row, cmd.term}];
                mul_b_reg <= proj_mem_reg[{cmd.term, cmd.col}];
            end
            MM_SQ:
            begin
                mul_a_reg <= comp_reg[cmd.term];
                mul_b_reg <= comp_reg[cmd.term];
            end
            default:
            begin
                mul_a_reg <= plane_vld_reg[cmd.plane] ?
                             plane_mem_reg[{cmd.plane, cmd.term}] : '0;
                mul_b_reg <= coord;
            end
        endcase
        d1_reg   <= plane_vld_reg[cmd.plane] ? plane_mem_reg[{cmd.plane, 2'd3}] : '0;
        prod_reg <= P2W'(mul_a_reg) * P2W'(mul_b_reg);
        d2_reg   <= d1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_next;
            tag2_reg <= tag1_reg;
        end
    end

    // accumulate stage sums
    always_comb
    begin
        fx    = fx_of(prod_reg);
        vsum  = (tag2_reg.first ? '0 : vacc_reg) + (W + 2)'(fx);
        dsum  = (tag2_reg.first ? '0 : dacc_reg) + (W + 2)'(fx);
        pdist = (W + 3)'(dsum) + (W + 3)'(d2_reg);
        pin   = (tag2_reg.cfirst ? 1'b0 : plane_in_reg) | (pdist >= 0);
    end

    always_ff @(posedge clk)
    begin
        if (tag2_reg.vld)
        begin
            unique case (tag2_reg.mode)
                MM_VP:
                begin
                    vacc_reg <= vsum;
                    if (tag2_reg.last)
                        vp_mem_reg[tag2_reg.idx] <= sat_w(P2W'(vsum));
                end
                MM_SQ:
                    sq_acc_reg <= (tag2_reg.first ? '0 : sq_acc_reg)
                                  + (P2W + 2)'(unsigned'(prod_reg));
                default:
                    dacc_reg <= dsum;
            endcase
        end
    end

    // distance decisions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_out_reg  <= 1'b0;
            plane_in_reg <= 1'b0;
        end
        else if (cmd.cap)
            any_out_reg <= 1'b0;
        else if (tag2_reg.vld && tag2_reg.mode == MM_DIST && tag2_reg.last)
        begin
            if (!box_reg)
            begin
                if (pdist < -((W + 3)'(r_reg)))
                    any_out_reg <= 1'b1;
            end
            else
            begin
                plane_in_reg <= pin;
                if (tag2_reg.clast && !pin)
                    any_out_reg <= 1'b1;
            end
        end
    end

    // plane component extraction
    always_ff @(posedge clk)
    begin
        vp_a_reg      <= vp_mem_reg[{cmd.term, 2'd3}];
        vp_b_reg      <= vp_mem_reg[{cmd.term, cmd.plane[2:1]}];
        ext_k_reg     <= cmd.term;
        ext_minus_reg <= PLANE_MINUS[cmd.plane];
        if (ext_vld_reg)
            comp_reg[ext_k_reg] <= sat_w(ext_minus_reg ?
                                         P2W'(vp_a_reg) - P2W'(vp_b_reg) :
                                         P2W'(vp_a_reg) + P2W'(vp_b_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_vld_reg <= 1'b0;
        else
            ext_vld_reg <= cmd.ext_issue;
    end

    // square root, one result bit a cycle
    always_comb
    begin
        srem_sh = {srem_reg, s_reg[P2W-1:P2W-2]};
        strial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
            scnt_reg      <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sqrt_busy_reg <= 1'b1;
            scnt_reg      <= CW'(W - 1);
        end
        else if (sqrt_busy_reg)
        begin
            scnt_reg <= scnt_reg - CW'(1);
            if (scnt_reg == '0)
                sqrt_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            s_reg    <= sq_acc_reg[P2W-1:0];
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (sqrt_busy_reg)
        begin
            s_reg <= {s_reg[P2W-3:0], 2'b00};
            if (srem_sh >= strial)
            begin
                srem_reg <= (W + 1)'(srem_sh - strial);
                root_reg <= {root_reg[W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh[W:0];
                root_reg <= {root_reg[W-2:0], 1'b0};
            end
            if (scnt_reg == '0)
                len_reg <= (srem_sh >= strial) ? {root_reg[W-2:0], 1'b1}
                                               : {root_reg[W-2:0], 1'b0};
        end
    end

    // restoring divider, one quotient bit a cycle
    always_comb
    begin
        cmag    = comp_reg[cmd.term][W-1] ? W'(-comp_reg[cmd.term])
                                          : W'(comp_reg[cmd.term]);
        drem_sh = {drem_reg, num_reg[NW-1]};
        if (drem_sh >= {1'b0, len_reg})
        begin
            drem_next = W'(drem_sh - {1'b0, len_reg});
            q_next    = {q_reg[NW-2:0], 1'b1};
        end
        else
        begin
            drem_next = drem_sh[W-1:0];
            q_next    = {q_reg[NW-2:0], 1'b0};
        end
        if (div_neg_reg)
            div_res = (q_next > Q_HALF) ? MINV[W-1:0] : W'(-q_next[W-1:0]);
        else
            div_res = (q_next > Q_HALF - NW'(1)) ? MAXV[W-1:0] : q_next[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= CW'(NW - 1);
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - CW'(1);
            if (dcnt_reg == '0)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg      <= {cmag, {F{1'b0}}};
            drem_reg     <= '0;
            q_reg        <= '0;
            div_neg_reg  <= comp_reg[cmd.term][W-1];
            div_addr_reg <= {cmd.plane, cmd.term};
        end
        else if (div_busy_reg)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            drem_reg <= drem_next;
            q_reg    <= q_next;
        end
    end

    // plane store write port
    always_comb
    begin
        pw_en   = cmd.copy_write || (div_busy_reg && dcnt_reg == '0);
        pw_addr = cmd.copy_write ? {cmd.plane, cmd.term} : div_addr_reg;
        pw_data = cmd.copy_write ? comp_reg[cmd.term] : div_res;
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
            plane_mem_reg[pw_addr] <= pw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_vld_reg <= '0;
        else if (pw_en)
            plane_vld_reg[pw_addr[4:2]] <= 1'b1;
    end

endmodule

@@ design/frustum_cull_test_core.sv @@
// Top level of the frustum cull test block: controller plus datapath.
// Sphere and box tests run from the beat to the done strobe, three products per
// corner through one shared multiplier. Build time depends on whether each plane
// is normalized and is set by the bit-serial square root and divider.
// One item at a time; busy is high until the item finishes.
// Results show for one cycle on done; the receiver cannot stall.
// rst_n clears control and the plane valid bits, so planes read as zero.
module frustum_cull_test_core #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [4:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] point_a_x,
    input  logic signed [31:0] point_a_y,
    input  logic signed [31:0] point_a_z,
    input  logic signed [31:0] point_b_x,
    input  logic signed [31:0] point_b_y,
    input  logic signed [31:0] point_b_z,
    input  logic [30:0]        sphere_radius,
    output logic               done,
    output logic               visible
);
    import fct_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    fct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // arithmetic and storage
    fct_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .element_index (element_index),
        .element_value (element_value),
        .point_a_x     (point_a_x),
        .point_a_y     (point_a_y),
        .point_a_z     (point_a_z),
        .point_b_x     (point_b_x),
        .point_b_y     (point_b_y),
        .point_b_z     (point_b_z),
        .sphere_radius (sphere_radius),
        .visible       (visible)
    );

endmodule

@@ design/fct_checker.sv @@
// Port-level checker for the frustum cull test block, with its bind.
module fct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] operation
);
    import fct_pkg::*;

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // result strobe only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // strobe lasts one cycle and frees the block
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("done longer than one cycle");

    // a load finishes after its write state with no result
    a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> (busy && !done) ##1 !busy)
        else $error("load beat timing wrong");

endmodule

bind frustum_cull_test_core fct_checker u_fct_checker (.*);

@@ tb/tb_frustum_cull_test_core.sv @@
// Self-checking testbench for frustum_cull_test_core: builds planes, culls spheres and boxes.
`timescale 1ns / 100ps

module tb_frustum_cull_test_core;

    import fct_pkg::*;

    localparam int  FRAC   = 16;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint EPS  = ((64'sd1 <<< FRAC) + 5000) / 10000;
    localparam int  N_RANDOM = 1450;
    localparam int  DRAIN_CYCLES = 600;

    typedef struct {
        op_t         op;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [31:0] ax, ay, az, bx, by, bz;
        logic [30:0] rad;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [4:0]  element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_a_x, point_a_y, point_a_z;
    logic signed [31:0] point_b_x, point_b_y, point_b_z;
    logic [30:0] sphere_radius;
    logic        done;
    logic        visible;

    // Culling scoreboard: mirrors matrices and planes, queues visibility flags
    class cull_scoreboard;
        longint view_m[16];
        longint proj_m[16];
        longint planes[24];
        bit     vis_q[$];
        int     mismatches;

        function new();
            foreach (view_m[i]) view_m[i] = 0;
            foreach (proj_m[i]) proj_m[i] = 0;
            foreach (planes[i]) planes[i] = 0;
            mismatches = 0;
        endfunction

        function longint sat(longint v);
            return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
        endfunction

        function longint word_of(logic [31:0] x);
            return longint'($signed(x));
        endfunction

        // product shifted down, truncated toward zero, saturated
        function longint qmul(longint a, longint b);
            longint p;
            longint m;
            bit     neg;
            p = a * b;
            neg = (a < 0) != (b < 0);
            m = (p < 0) ? -p : p;
            m = m >>> FRAC;
            if (neg) return (m > -WMIN) ? WMIN : -m;
            return (m > WMAX) ? WMAX : m;
        endfunction

        function longint isqrt(logic [127:0] s);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] cc;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                cc = {64'd0, c} * {64'd0, c};
                if (cc <= s) r = c;
            end
            return longint'(r);
        endfunction

        function longint qdiv(longint n, longint len);
            longint m;
            longint q;
            m = (n < 0) ? -n : n;
            q = (m <<< FRAC) / len;
            if (n < 0) return (q > -WMIN) ? WMIN : -q;
            return (q > WMAX) ? WMAX : q;
        endfunction

        function void build();
            longint       vp[16];
            longint       acc;
            longint       c4, ca, m, len;
            logic [127:0] s;
            int           a;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += qmul(view_m[i*4+k], proj_m[k*4+j]);
                    vp[i*4+j] = sat(acc);
                end
            // left/right, top/bottom, near/far: column 4 plus or minus column a
            for (int p = 0; p < 6; p++) begin
                a = p / 2;
                for (int k = 0; k < 4; k++) begin
                    c4 = vp[k*4+3];
                    ca = vp[k*4+a];
                    planes[p*4+k] = sat((p == 0 || p == 3 || p == 4) ? c4 + ca : c4 - ca);
                end
                s = 0;
                for (int k = 0; k < 3; k++) begin
                    m = planes[p*4+k] < 0 ? -planes[p*4+k] : planes[p*4+k];
                    s += {64'd0, m} * {64'd0, m};
                end
                len = isqrt(s);
                if (len > EPS)
                    for (int k = 0; k < 4; k++)
                        planes[p*4+k] = qdiv(planes[p*4+k], len);
            end
        endfunction

        function longint plane_dist(int p, longint x, longint y, longint z);
            return qmul(planes[p*4], x) + qmul(planes[p*4+1], y)
                 + qmul(planes[p*4+2], z) + planes[p*4+3];
        endfunction

        // accepted input beat
        function void note_item(item_t it);
            longint ax, ay, az, bx, by, bz, r, x, y, z;
            bit     vis, all_out;
            case (it.op)
                OP_LOAD:
                begin
                    if (it.idx < 16) view_m[it.idx] = word_of(it.val);
                    else proj_m[it.idx - 16] = word_of(it.val);
                end
                OP_BUILD: build();
                default:
                begin
                    ax = word_of(it.ax); ay = word_of(it.ay); az = word_of(it.az);
                    bx = word_of(it.bx); by = word_of(it.by); bz = word_of(it.bz);
                    r = longint'(it.rad);
                    vis = 1;
                    for (int p = 0; p < 6 && vis; p++) begin
                        if (it.op == OP_SPHERE) begin
                            if (plane_dist(p, ax, ay, az) < -r) vis = 0;
                        end
                        else begin
                            all_out = 1;
                            for (int c = 0; c < 8 && all_out; c++) begin
                                x = c[0] ? bx : ax;
                                y = c[1] ? by : ay;
                                z = c[2] ? bz : az;
                                if (plane_dist(p, x, y, z) >= 0) all_out = 0;
                            end
                            if (all_out) vis = 0;
                        end
                    end
                    vis_q.push_back(vis);
                end
            endcase
        endfunction

        // result beat on done
        function void check_result(bit got);
            bit exp_vis;
            if (vis_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result visible=%0d", got);
                return;
            end
            exp_vis = vis_q.pop_front();
            if (exp_vis !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: visible expected %0d actual %0d", exp_vis, got);
            end
        endfunction
    endclass

    cull_scoreboard sb;
    int n_sent;

    frustum_cull_test_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .element_index(element_index),
        .element_value(element_value),
        .point_a_x(point_a_x), .point_a_y(point_a_y), .point_a_z(point_a_z),
        .point_b_x(point_b_x), .point_b_y(point_b_y), .point_b_z(point_b_z),
        .sphere_radius(sphere_radius), .done(done), .visible(visible)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(visible);
    end

    // run limit
    initial
    begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // drive one beat, hold until accepted
    task automatic send_item(item_t it);
        @(negedge clk);
        operation = it.op;
        element_index = it.idx;
        element_value = it.val;
        point_a_x = it.ax; point_a_y = it.ay; point_a_z = it.az;
        point_b_x = it.bx; point_b_y = it.by; point_b_z = it.bz;
        sphere_radius = it.rad;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(99) < 28) idle_cycles($urandom_range(6, 1));
    endtask

    task automatic wait_results();
        while (sb.vis_q.size() != 0) @(posedge clk);
    endtask

    function automatic item_t blank_item(op_t op);
        item_t it;
        it.op = op;
        it.idx = 5'($urandom);
        it.val = $urandom;
        it.ax = $urandom; it.ay = $urandom; it.az = $urandom;
        it.bx = $urandom; it.by = $urandom; it.bz = $urandom;
        it.rad = 31'($urandom);
        return it;
    endfunction

    function automatic item_t load_item(int idx, logic [31:0] v);
        item_t it;
        it = blank_item(OP_LOAD);
        it.idx = 5'(idx);
        it.val = v;
        return it;
    endfunction

    function automatic logic [31:0] small_coord();
        return $signed($urandom_range(40 << 16)) - (20 << 16);
    endfunction

    function automatic item_t test_item(op_t op, bit short_range);
        item_t it;
        it = blank_item(op);
        if (short_range) begin
            it.ax = small_coord(); it.ay = small_coord(); it.az = small_coord();
            it.bx = small_coord(); it.by = small_coord(); it.bz = small_coord();
            it.rad = 31'($urandom_range(8 << 16));
        end
        return it;
    endfunction

    // plausible camera: translated view, perspective projection with jitter
    task automatic load_camera(bit allow_idle);
        logic [31:0] m[32];
        foreach (m[i]) m[i] = 0;
        m[0] = 32'h10000; m[5] = 32'h10000; m[10] = 32'h10000; m[15] = 32'h10000;
        m[12] = $signed(small_coord()) >>> 2;
        m[13] = $signed(small_coord()) >>> 2;
        m[14] = $signed(small_coord()) >>> 2;
        if ($urandom_range(1)) begin
            m[1] = $urandom_range(20000); m[4] = -$signed(m[1]);
        end
        m[16] = $urandom_range(32'h18000, 32'h8000);
        m[21] = $urandom_range(32'h18000, 32'h8000);
        m[26] = $urandom_range(32'h10800, 32'h10000);
        m[27] = 32'h10000;
        m[30] = -$signed($urandom_range(32'h20000, 32'h1000));
        for (int i = 0; i < 32; i++) begin
            send_item(load_item(i, m[i]));
            maybe_idle(allow_idle);
        end
    endtask

    initial
    begin
        item_t it;
        int    r;
        bit    allow;
        sb = new();
        n_sent = 0;
        start = 1'b0;
        operation = OP_LOAD;
        element_index = '0;
        element_value = '0;
        point_a_x = '0; point_a_y = '0; point_a_z = '0;
        point_b_x = '0; point_b_y = '0; point_b_z = '0;
        sphere_radius = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tests against zero planes before any build
        send_item(test_item(OP_SPHERE, 1));
        send_item(test_item(OP_BOX, 0));

        // degenerate all-zero matrices, planes stay unnormalized
        for (int i = 0; i < 32; i++) send_item(load_item(i, 32'h0));
        send_item(blank_item(OP_BUILD));
        send_item(test_item(OP_SPHERE, 1));

        // saturating matrices
        for (int i = 0; i < 32; i++)
            send_item(load_item(i, (i % 3 == 0) ? 32'h80000000 : 32'h7fffffff));
        send_item(blank_item(OP_BUILD));
        send_item(test_item(OP_BOX, 1));

        // sane camera and field extremes
        load_camera(0);
        send_item(blank_item(OP_BUILD));
        it = test_item(OP_SPHERE, 1);
        it.ax = 0; it.ay = 0; it.az = 32'h50000; it.rad = 0;
        send_item(it);
        it.az = 32'hfff00000; send_item(it);
        it.rad = 31'h7fffffff; send_item(it);
        it.ax = 32'h7fffffff; it.ay = 32'h80000000; it.az = 32'h7fffffff; it.rad = 0;
        send_item(it);
        it = test_item(OP_BOX, 1);
        it.ax = 32'hfffe0000; it.ay = 32'hfffe0000; it.az = 32'h10000;
        it.bx = 32'h20000; it.by = 32'h20000; it.bz = 32'h80000;
        send_item(it);
        // inverted box
        it.ax = 32'h20000; it.bx = 32'hfffe0000; send_item(it);
        it.ax = 32'h80000000; it.ay = 32'h80000000; it.az = 32'h80000000;
        it.bx = 32'h7fffffff; it.by = 32'h7fffffff; it.bz = 32'h7fffffff;
        send_item(it);
        it.az = 32'hff000000; it.bz = 32'hff100000; send_item(it);

        // random traffic until the item count is reached; one long stretch without gaps
        for (int n = 0; n_sent < N_RANDOM; n++) begin
            allow = !(n >= 300 && n < 450);
            if (n == 150 || n == 550) begin
                idle_cycles(1);
                wait_results();
            end
            r = $urandom_range(99);
            if (r < 3) begin
                load_camera(allow);
                send_item(blank_item(OP_BUILD));
            end
            else if (r < 10) begin
                it = blank_item(OP_LOAD);
                if ($urandom_range(3) != 0)
                    it.val = $signed($urandom_range(32'h30000)) - 32'h18000;
                send_item(it);
            end
            else if (r < 13) send_item(blank_item(OP_BUILD));
            else if (r < 58) send_item(test_item(OP_SPHERE, $urandom_range(9) < 7));
            else send_item(test_item(OP_BOX, $urandom_range(9) < 7));
            maybe_idle(allow);
        end
        idle_cycles(1);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.vis_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
